// ===== design/pbuf_pkg.sv =====
// Types and constants shared by the padded BGR unpack and flip unit.
`timescale 1ns / 1ps

package pbuf_pkg;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 27;
  localparam int SKIP_BITS     = 16;
  localparam int ROW_BITS      = 24;
  localparam int PIX_BITS      = 24;
  localparam int TOTAL_BITS    = 25;
  localparam int IDX_BITS      = 30;
  localparam int DEST_BITS     = 26;
  localparam int FB_BITS       = 27;

  localparam logic [TOTAL_BITS-1:0] PIX_LIMIT    = TOTAL_BITS'(1 << PIX_BITS);
  localparam logic [7:0]            ALPHA_OPAQUE = 8'hff;
  localparam logic [2:0]            BPP_THREE    = 3'd3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FLIP_MODE       = 3'd0,
    REG_BYTES_PER_PIXEL = 3'd1,
    REG_FRAME_WIDTH     = 3'd2,
    REG_FRAME_HEIGHT    = 3'd3,
    REG_LEAD_SKIP_BYTES = 3'd4,
    REG_FRAME_BYTES     = 3'd5
  } cfg_reg_t;

  typedef enum logic [3:0] {
    PH_SKIP     = 4'b0001,
    PH_PIXEL    = 4'b0010,
    PH_PAD      = 4'b0100,
    PH_PAD_LAST = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
    logic       last;
  } pix_data_t;

endpackage

// ===== design/padded_bgr_unpack_flip_unit.sv =====
// Padded BGR(A) byte stream unpacker with row/column mirrored destination index.
`timescale 1ns / 1ps

// Usage:
//   Source channel (src_valid, src_stall, source_byte) carries one raw image
//   byte per word; it is taken at every edge where src_valid is high and
//   src_stall is low. Result channel (res_valid, res_stall, ...) carries one
//   pixel per word: destination byte index, BGRA bytes, last_pixel and
//   out_of_range.
//   Configuration is written through cfg_write / cfg_index / cfg_data while
//   the block is idle; register indexes follow cfg_reg_t.
//   Throughput: one source byte per cycle while src_stall is low, with no gaps
//   between frames. A pixel's final byte is taken as the operand register
//   loads; the pixel then passes the multiply register and the result
//   register before it appears on res_valid.
//   Skipped lead bytes and row padding produce no result.
//   Reset: registers return to their defaults, the stream state re-arms at
//   the start of a frame, and all result stages empty.
//   Stall: while res_stall is high the result word holds; the two inner
//   stages keep filling, and src_stall rises only when all three hold a pixel.
module padded_bgr_unpack_flip_unit #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [pbuf_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [pbuf_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                src_valid,
  output logic                                src_stall,
  input  logic [7:0]                          source_byte,
  output logic                                res_valid,
  input  logic                                res_stall,
  output logic [pbuf_pkg::DEST_BITS-1:0]      dest_index,
  output logic [7:0]                          blue,
  output logic [7:0]                          green,
  output logic [7:0]                          red,
  output logic [7:0]                          alpha,
  output logic                                last_pixel,
  output logic                                out_of_range
);
  import pbuf_pkg::*;

  localparam int W_BITS   = $clog2(MAX_WIDTH + 1);
  localparam int H_BITS   = $clog2(MAX_HEIGHT + 1);
  localparam int COL_BITS = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  // configuration
  logic [1:0]            flip_mode;
  logic                  bpp3;
  logic [W_BITS-1:0]     width;
  logic [H_BITS-1:0]     height;
  logic [SKIP_BITS-1:0]  lead_skip;
  logic [FB_BITS-1:0]    frame_bytes;
  logic [TOTAL_BITS-1:0] pix_total;

  logic [31:0]           cfg_w32;
  logic [31:0]           cfg_h32;
  logic [TOTAL_BITS:0]   cfg_total;

  always_comb begin
    cfg_w32 = {19'b0, cfg_data[12:0]};
    if (cfg_w32 == 32'd0) begin
      cfg_w32 = 32'd1;
    end else if (cfg_w32 > 32'(MAX_WIDTH)) begin
      cfg_w32 = 32'(MAX_WIDTH);
    end
    cfg_h32 = {19'b0, cfg_data[12:0]};
    if (cfg_h32 == 32'd0) begin
      cfg_h32 = 32'd1;
    end else if (cfg_h32 > 32'(MAX_HEIGHT)) begin
      cfg_h32 = 32'(MAX_HEIGHT);
    end
    cfg_total = (TOTAL_BITS + 1)'(({1'b0, cfg_data} + 28'd3) >> 2);
    if (cfg_total == '0) begin
      cfg_total = (TOTAL_BITS + 1)'(1);
    end else if (cfg_total > {1'b0, PIX_LIMIT}) begin
      cfg_total = {1'b0, PIX_LIMIT};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flip_mode   <= 2'd0;
      bpp3        <= 1'b0;
      width       <= W_BITS'(1);
      height      <= H_BITS'(1);
      lead_skip   <= '0;
      frame_bytes <= FB_BITS'(4);
      pix_total   <= TOTAL_BITS'(1);
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_FLIP_MODE:       flip_mode <= cfg_data[1:0];
        REG_BYTES_PER_PIXEL: bpp3 <= (cfg_data[2:0] == BPP_THREE);
        REG_FRAME_WIDTH:     width <= W_BITS'(cfg_w32);
        REG_FRAME_HEIGHT:    height <= H_BITS'(cfg_h32);
        REG_LEAD_SKIP_BYTES: lead_skip <= cfg_data[SKIP_BITS-1:0];
        REG_FRAME_BYTES: begin
          frame_bytes <= cfg_data[FB_BITS-1:0];
          pix_total   <= cfg_total[TOTAL_BITS-1:0];
        end
        default: ;
      endcase
    end
  end

  // stream state
  phase_t                phase, phase_next;
  logic [SKIP_BITS-1:0]  skip_count, skip_count_next;
  logic [1:0]            byte_slot, byte_slot_next;
  logic [7:0]            hold [3];
  logic [7:0]            hold_next [3];
  logic [COL_BITS-1:0]   column, column_next;
  logic [ROW_BITS-1:0]   row, row_next;
  logic [1:0]            pad_left, pad_left_next;
  logic [PIX_BITS-1:0]   pixel_count, pixel_count_next;

  // pipeline
  logic                  v1, v2, ov;
  logic                  ready_o, ready2;
  logic                  src_take;
  logic [IDX_BITS-1:0]   s1_y, s1_x;
  logic [W_BITS-1:0]     s1_w;
  pix_data_t             s1_pix;
  logic [IDX_BITS-1:0]   s2_prod, s2_x;
  pix_data_t             s2_pix;
  logic [IDX_BITS+W_BITS-1:0] prod_full;
  logic [IDX_BITS-1:0]   sum_idx;
  logic [31:0]           idx32;

  logic                  do_pix, emit, row_end, last, in_skip;
  logic [1:0]            pad;
  logic [7:0]            alpha_new;
  logic [IDX_BITS-1:0]   mx, my, y_term, x_term;

  assign ready_o   = !ov || !res_stall;
  assign ready2    = !v2 || ready_o;
  assign src_stall = v1 && !ready2;
  assign src_take  = src_valid && !src_stall;

  assign pad     = bpp3 ? 2'({2'b00, width}) : 2'd0;
  assign row_end = (32'(column) + 32'd1) >= 32'(width);
  assign last    = (TOTAL_BITS'(pixel_count) + TOTAL_BITS'(1)) >= pix_total;
  assign in_skip = skip_count < lead_skip;
  assign mx      = IDX_BITS'(width) - IDX_BITS'(1) - IDX_BITS'(column);
  assign my      = IDX_BITS'(height) - IDX_BITS'(1) - IDX_BITS'(row);

  always_comb begin
    if (flip_mode == 2'd0) begin
      y_term = '0;
      x_term = IDX_BITS'(pixel_count);
    end else begin
      y_term = flip_mode[1] ? my : IDX_BITS'(row);
      x_term = flip_mode[0] ? mx : IDX_BITS'(column);
    end
  end

  always_comb begin
    phase_next       = phase;
    skip_count_next  = skip_count;
    byte_slot_next   = byte_slot;
    hold_next        = hold;
    column_next      = column;
    row_next         = row;
    pad_left_next    = pad_left;
    pixel_count_next = pixel_count;
    do_pix           = 1'b0;
    emit             = 1'b0;
    alpha_new        = ALPHA_OPAQUE;
    if (src_take) begin
      case (phase)
        PH_SKIP: begin
          if (in_skip) begin
            skip_count_next = skip_count + SKIP_BITS'(1);
          end else begin
            phase_next = PH_PIXEL;
            do_pix     = 1'b1;
          end
        end
        PH_PIXEL: do_pix = 1'b1;
        PH_PAD, PH_PAD_LAST: begin
          if (pad_left > 2'd1) begin
            pad_left_next = pad_left - 2'd1;
          end else if (phase == PH_PAD_LAST) begin
            phase_next       = PH_SKIP;
            skip_count_next  = '0;
            byte_slot_next   = 2'd0;
            column_next      = '0;
            row_next         = '0;
            pad_left_next    = 2'd0;
            pixel_count_next = '0;
          end else begin
            pad_left_next = 2'd0;
            phase_next    = PH_PIXEL;
          end
        end
        default: ;
      endcase
      if (do_pix) begin
        if (byte_slot != 2'd3) begin
          hold_next[byte_slot] = source_byte;
          byte_slot_next       = byte_slot + 2'd1;
          emit                 = (byte_slot == 2'd2) && bpp3;
        end else begin
          alpha_new = source_byte;
          emit      = 1'b1;
        end
        if (emit) begin
          byte_slot_next   = 2'd0;
          pixel_count_next = pixel_count + PIX_BITS'(1);
          if (row_end) begin
            column_next = '0;
            row_next    = row + ROW_BITS'(1);
          end else begin
            column_next = column + COL_BITS'(1);
          end
          if (row_end && (pad != 2'd0)) begin
            pad_left_next = pad;
            phase_next    = last ? PH_PAD_LAST : PH_PAD;
          end else if (last) begin
            phase_next       = PH_SKIP;
            skip_count_next  = '0;
            column_next      = '0;
            row_next         = '0;
            pad_left_next    = 2'd0;
            pixel_count_next = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SKIP;
      skip_count  <= '0;
      byte_slot   <= 2'd0;
      column      <= '0;
      row         <= '0;
      pad_left    <= 2'd0;
      pixel_count <= '0;
    end else begin
      phase       <= phase_next;
      skip_count  <= skip_count_next;
      byte_slot   <= byte_slot_next;
      column      <= column_next;
      row         <= row_next;
      pad_left    <= pad_left_next;
      pixel_count <= pixel_count_next;
    end
  end

  always_ff @(posedge clk) begin
    hold <= hold_next;
  end

  // stage 1: index operands and pixel bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (emit) begin
      v1 <= 1'b1;
    end else if (ready2) begin
      v1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      s1_y         <= y_term;
      s1_x         <= x_term;
      s1_w         <= width;
      s1_pix.blue  <= hold_next[0];
      s1_pix.green <= hold_next[1];
      s1_pix.red   <= hold_next[2];
      s1_pix.alpha <= alpha_new;
      s1_pix.last  <= last;
    end
  end

  // stage 2: row product
  assign prod_full = s1_y * s1_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ready2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && v1) begin
      s2_prod <= prod_full[IDX_BITS-1:0];
      s2_x    <= s1_x;
      s2_pix  <= s1_pix;
    end
  end

  // result word: final index and range check
  assign sum_idx = s2_prod + s2_x;
  assign idx32   = {sum_idx, 2'b00};

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (ready_o) begin
      ov <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && v2) begin
      dest_index   <= idx32[DEST_BITS-1:0];
      blue         <= s2_pix.blue;
      green        <= s2_pix.green;
      red          <= s2_pix.red;
      alpha        <= s2_pix.alpha;
      last_pixel   <= s2_pix.last;
      out_of_range <= idx32 >= {5'b0, frame_bytes};
    end
  end

  assign res_valid = ov;

  a_pad_only_in_pad_phase: assert property (@(posedge clk) disable iff (rst)
    (pad_left == 2'd0) || (phase == PH_PAD) || (phase == PH_PAD_LAST))
    else $error("pad count live outside padding");

  a_slot_idle_outside_pixel: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_PIXEL) |-> (byte_slot == 2'd0))
    else $error("partial pixel outside pixel phase");

  a_last_rearms: assert property (@(posedge clk) disable iff (rst)
    (emit && last) |=> (pixel_count == '0) || (phase == PH_PAD_LAST))
    else $error("frame did not re-arm after last pixel");

  a_pad_last_ends: assert property (@(posedge clk) disable iff (rst)
    (src_take && (phase == PH_PAD_LAST) && (pad_left <= 2'd1)) |=>
      (phase == PH_SKIP) && (pixel_count == '0))
    else $error("final padding did not re-arm");

endmodule

// ===== sim/tb_padded_bgr_unpack_flip_unit.sv =====
// Testbench for padded_bgr_unpack_flip_unit: byte stream stimulus, pixel prediction, checking.
`timescale 1ns / 1ps

module tb_padded_bgr_unpack_flip_unit;
  import pbuf_pkg::*;

  localparam logic [1:0] FLIP_NONE = 2'd0;
  localparam logic [1:0] FLIP_COLS = 2'd1;
  localparam logic [1:0] FLIP_ROWS = 2'd2;
  localparam logic [1:0] FLIP_BOTH = 2'd3;
  localparam int unsigned MAX_W = 4096;
  localparam int unsigned MAX_H = 4096;
  localparam int unsigned RANDOM_BYTES = 300;
  localparam int unsigned MAX_REPORTS = 20;

  typedef struct {
    logic [DEST_BITS-1:0] dest;
    logic [7:0]           blue;
    logic [7:0]           green;
    logic [7:0]           red;
    logic [7:0]           alpha;
    logic                 last;
    logic                 oor;
  } pixel_word_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_write = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic                     src_valid = 1'b0;
  logic                     src_stall;
  logic [7:0]               source_byte = '0;
  logic                     res_valid;
  logic                     res_stall = 1'b0;
  logic [DEST_BITS-1:0]     dest_index;
  logic [7:0]               blue;
  logic [7:0]               green;
  logic [7:0]               red;
  logic [7:0]               alpha;
  logic                     last_pixel;
  logic                     out_of_range;

  padded_bgr_unpack_flip_unit i_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // register copies
  logic [1:0]  flip_mode_r;
  logic [2:0]  bpp_r;
  logic [12:0] width_r;
  logic [12:0] height_r;
  logic [15:0] lead_skip_r;
  logic [26:0] frame_bytes_r;

  // stream state
  phase_t      ph;
  logic [15:0] skip_count;
  int unsigned byte_slot;
  int unsigned pixel_hold;
  int unsigned column;
  logic [23:0] row;
  int unsigned pad_left;
  logic [23:0] pixel_count;

  pixel_word_t pixel_q[$];
  pixel_word_t want;
  int unsigned frames_done = 0;
  int unsigned bytes_sent = 0;
  int unsigned errors = 0;
  int unsigned src_idle_pct = 0;
  int unsigned stall_pct = 0;
  int          stall_left = 0;

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned lim);
    if (v == 0) return 1;
    return (v > lim) ? lim : v;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  function automatic int unsigned pick_pct();
    case ($urandom_range(3))
      0: return 0;
      1: return 10;
      2: return 30;
      default: return 60;
    endcase
  endfunction

  task automatic rearm_frame();
    ph = PH_SKIP;
    skip_count = '0;
    byte_slot = 0;
    column = 0;
    row = '0;
    pad_left = 0;
    pixel_count = '0;
    frames_done++;
  endtask

  task automatic reset_model();
    flip_mode_r = FLIP_NONE;
    bpp_r = 3'd4;
    width_r = 13'd1;
    height_r = 13'd1;
    lead_skip_r = '0;
    frame_bytes_r = 27'd4;
    pixel_hold = 0;
    rearm_frame();
  endtask

  task automatic absorb_byte(input logic [7:0] b);
    int unsigned bpp, w, h, mx, my, idx, total, pad;
    bit row_end, last;
    pixel_word_t px;
    bpp = (bpp_r == BPP_THREE) ? 3 : 4;
    w = clamp_dim(width_r, MAX_W);
    h = clamp_dim(height_r, MAX_H);
    if (ph == PH_SKIP) begin
      if (skip_count < lead_skip_r) begin
        skip_count = skip_count + 16'd1;
        return;
      end
      ph = PH_PIXEL;
    end
    if (ph == PH_PAD || ph == PH_PAD_LAST) begin
      if (pad_left > 1) begin
        pad_left--;
      end else if (ph == PH_PAD_LAST) begin
        rearm_frame();
      end else begin
        pad_left = 0;
        ph = PH_PIXEL;
      end
      return;
    end
    if (byte_slot < 3) begin
      pixel_hold |= 32'(b) << (8 * byte_slot);
      byte_slot++;
      if (byte_slot < bpp) return;
      px.alpha = ALPHA_OPAQUE;
    end else begin
      px.alpha = b;
    end
    mx = w - 1 - column;
    my = h - 1 - 32'(row);
    case (flip_mode_r)
      FLIP_COLS: idx = (32'(row) * w + mx) * 4;
      FLIP_ROWS: idx = (my * w + column) * 4;
      FLIP_BOTH: idx = (my * w + mx) * 4;
      default:   idx = 32'(pixel_count) * 4;
    endcase
    total = (32'(frame_bytes_r) + 3) >> 2;
    if (total == 0) total = 1;
    if (total > 32'(PIX_LIMIT)) total = 32'(PIX_LIMIT);
    last = (32'(pixel_count) + 1) >= total;
    px.dest = idx[DEST_BITS-1:0];
    px.blue = pixel_hold[7:0];
    px.green = pixel_hold[15:8];
    px.red = pixel_hold[23:16];
    px.last = last;
    px.oor = idx >= 32'(frame_bytes_r);
    pixel_q.push_back(px);
    pixel_hold = 0;
    byte_slot = 0;
    pad = (4 - ((w * bpp) & 3)) & 3;
    row_end = column >= w - 1;
    if (row_end) begin
      column = 0;
      row = row + 24'd1;
    end else begin
      column++;
    end
    pixel_count = pixel_count + 24'd1;
    if (row_end && pad != 0) begin
      pad_left = pad;
      ph = last ? PH_PAD_LAST : PH_PAD;
    end else if (last) begin
      rearm_frame();
    end
  endtask

  task automatic report_mismatch(input string msg);
    if (errors < MAX_REPORTS) $display("%0t ERROR: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("%s got 0x%0h, wanted 0x%0h", name, got, exp_val));
  endtask

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (pixel_q.size() == 0) begin
        report_mismatch("result word with no pixel pending");
      end else begin
        want = pixel_q.pop_front();
        check_field("dest_index", 32'(dest_index), 32'(want.dest));
        check_field("blue", 32'(blue), 32'(want.blue));
        check_field("green", 32'(green), 32'(want.green));
        check_field("red", 32'(red), 32'(want.red));
        check_field("alpha", 32'(alpha), 32'(want.alpha));
        check_field("last_pixel", 32'(last_pixel), 32'(want.last));
        check_field("out_of_range", 32'(out_of_range), 32'(want.oor));
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      res_stall <= 1'b1;
    end else if ($urandom_range(99) < stall_pct) begin
      stall_left <= pick_gap() - 1;
      res_stall <= 1'b1;
    end else begin
      res_stall <= 1'b0;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = ($urandom_range(99) < src_idle_pct) ? pick_gap() : 0;
    if (gap != 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    src_valid <= 1'b1;
    source_byte <= b;
    @(posedge clk);
    while (src_stall) @(posedge clk);
    absorb_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame();
    int unsigned start;
    start = frames_done;
    while (frames_done == start) send_byte(8'($urandom));
  endtask

  task automatic drain();
    src_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t r, input logic [26:0] v);
    cfg_write <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    @(posedge clk);
    case (r)
      REG_FLIP_MODE:       flip_mode_r = v[1:0];
      REG_BYTES_PER_PIXEL: bpp_r = v[2:0];
      REG_FRAME_WIDTH:     width_r = v[12:0];
      REG_FRAME_HEIGHT:    height_r = v[12:0];
      REG_LEAD_SKIP_BYTES: lead_skip_r = v[15:0];
      REG_FRAME_BYTES:     frame_bytes_r = v;
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [1:0] flip, input logic [2:0] bpp,
                              input logic [12:0] w, input logic [12:0] h,
                              input logic [15:0] skip, input logic [26:0] fb);
    write_reg(REG_FLIP_MODE, 27'(flip));
    write_reg(REG_BYTES_PER_PIXEL, 27'(bpp));
    write_reg(REG_FRAME_WIDTH, 27'(w));
    write_reg(REG_FRAME_HEIGHT, 27'(h));
    write_reg(REG_LEAD_SKIP_BYTES, 27'(skip));
    write_reg(REG_FRAME_BYTES, fb);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    src_idle_pct = 0;
    stall_pct = 0;
    repeat (4) send_byte(8'h00);
    repeat (4) send_byte(8'hff);
    drain();
  endtask

  task automatic test_flip_modes();
    logic [1:0] modes[4];
    modes = '{FLIP_NONE, FLIP_COLS, FLIP_ROWS, FLIP_BOTH};
    src_idle_pct = 20;
    stall_pct = 20;
    foreach (modes[i]) begin
      program_regs(modes[i], 3'd3, 13'd2, 13'd2, 16'd1, 27'd16);
      send_frame();
      drain();
    end
  endtask

  task automatic test_dimension_clamps();
    src_idle_pct = 0;
    stall_pct = 30;
    program_regs(FLIP_BOTH, 3'd7, 13'd0, 13'd0, 16'd0, 27'd0);
    send_frame();
    drain();
    program_regs(FLIP_BOTH, 3'd4, 13'h1fff, 13'h1fff, 16'd0, 27'h7ffffff);
    repeat (12) send_byte(8'($urandom));
    drain();
    // shrink the frame mid-way: next pixel ends it
    program_regs(FLIP_COLS, 3'd3, 13'd4096, 13'd4096, 16'd0, 27'd4);
    send_frame();
    drain();
  endtask

  task automatic test_rows_beyond_height();
    src_idle_pct = 10;
    stall_pct = 10;
    program_regs(FLIP_ROWS, 3'd3, 13'd2, 13'd1, 16'd0, 27'd40);
    send_frame();
    drain();
  endtask

  task automatic test_lead_skip_extreme();
    src_idle_pct = 0;
    stall_pct = 0;
    program_regs(FLIP_NONE, 3'd3, 13'd1, 13'd1, 16'd150, 27'd4);
    send_frame();
    drain();
  endtask

  task automatic test_random_frames();
    int unsigned start, area;
    logic [1:0]  flip;
    logic [2:0]  bpp;
    logic [12:0] w, h;
    logic [15:0] skip;
    logic [26:0] fb;
    bit          noise;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      noise = ($urandom_range(7) == 0);
      flip = 2'($urandom);
      case ($urandom_range(4))
        0, 1: bpp = 3'd3;
        2, 3: bpp = 3'd4;
        default: bpp = 3'($urandom);
      endcase
      skip = ($urandom_range(9) < 7) ? 16'd0 : 16'($urandom_range(1, 6));
      if ($urandom_range(99) < 85) begin
        w = 13'($urandom_range(1, 6));
        h = 13'($urandom_range(1, 4));
        area = 4 * w * h;
      end else begin
        w = 13'($urandom);
        h = 13'($urandom);
        area = 64;
      end
      case ($urandom_range(9))
        0, 1: fb = 27'($urandom_range(0, area + 16));
        2: begin
          fb = 27'($urandom);
          noise = 1'b1;
        end
        default: fb = 27'(area);
      endcase
      drain();
      program_regs(flip, bpp, w, h, skip, fb);
      src_idle_pct = pick_pct();
      stall_pct = pick_pct();
      if (noise) begin
        repeat ($urandom_range(1, 24)) send_byte(8'($urandom));
      end else begin
        repeat ($urandom_range(1, 3)) send_frame();
      end
    end
    // close any open frame
    drain();
    program_regs(FLIP_NONE, 3'd4, 13'd1, 13'd1, 16'd0, 27'd4);
    send_frame();
    drain();
  endtask

  initial begin
    reset_model();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_flip_modes();
    test_dimension_clamps();
    test_rows_beyond_height();
    test_lead_skip_extreme();
    test_random_frames();
    if (errors == 0) begin
      $display("padded_bgr_unpack_flip_unit: match");
    end else begin
      $display("padded_bgr_unpack_flip_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("padded_bgr_unpack_flip_unit: mismatch");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/pbuf_pkg.sv
design/padded_bgr_unpack_flip_unit.sv
sim/tb_padded_bgr_unpack_flip_unit.sv
